// ===== rtl/imgdf_pkg.sv =====
// imgdf_pkg: shared types and constants of the image line deframer.
// Used by imgdf_parse and image_line_deframer; depends on nothing.
package imgdf_pkg;

  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 12;
  localparam int VALUE_W  = 16;
  localparam int HDR_ROW_W = 16;
  localparam int CFG_W    = 13;
  localparam int HIST_W   = 24;
  localparam int EFF_W_W  = 14;
  localparam int LEN_W    = 15;

  localparam logic [HIST_W-1:0] SYNC_PREFIX  = 24'h90EB00;
  localparam logic [HIST_W-1:0] HIST_CLEAR   = 24'hFFFFFF;
  localparam logic [BYTE_W-1:0] SYNC_LAST    = 8'h00;
  localparam logic [BYTE_W-1:0] ROW_OFS_LO   = 8'd8;
  localparam logic [BYTE_W-1:0] ROW_OFS_HI   = 8'd9;
  localparam logic [BYTE_W-1:0] SYNC_BYTES   = 8'd4;
  localparam logic [BYTE_W-1:0] MIN_HEADER   = 8'd12;
  localparam logic [CFG_W-1:0]  MAX_HEIGHT   = 13'd4096;

  localparam logic [CFG_W-1:0]  WIDTH_RST    = 13'd640;
  localparam logic [CFG_W-1:0]  HEIGHT_RST   = 13'd512;
  localparam logic [BYTE_W-1:0] HEADER_RST   = 8'd16;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_HEADER_BYTES = 2'd2
  } cfg_index_t;

  // Clamped configuration as seen by the parser.
  typedef struct packed {
    logic [EFF_W_W-1:0] width;
    logic [CFG_W-1:0]   height;
    logic [BYTE_W-1:0]  header;
  } eff_cfg_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [ROW_W-1:0]   pixel_row;
    logic [COL_W-1:0]   pixel_column;
    logic [VALUE_W-1:0] pixel_value;
    logic               frame_commit;
  } result_t;

endpackage

// ===== rtl/imgdf_parse.sv =====
// imgdf_parse: sync hunt, header and payload parser, one byte per cycle while take is high.
// Depends on imgdf_pkg; result is combinational from the byte and the state.
module imgdf_parse #(
  parameter int POS_W = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic [imgdf_pkg::BYTE_W-1:0]   data,
  input  imgdf_pkg::eff_cfg_t            cfg,
  output logic                           fire,
  output imgdf_pkg::result_t             res
);

  localparam int CMP_W = imgdf_pkg::LEN_W;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t                              phase, phase_next;
  logic [imgdf_pkg::HIST_W-1:0]        sync_history, sync_history_next;
  logic [POS_W-1:0]                    byte_pos, byte_pos_next;
  logic [imgdf_pkg::HDR_ROW_W-1:0]     cur_row, cur_row_next;
  logic                                row_ok, row_ok_next;
  logic [imgdf_pkg::HDR_ROW_W-1:0]     prev_row, prev_row_next;
  logic [imgdf_pkg::BYTE_W-1:0]        low_hold, low_hold_next;

  logic [POS_W-1:0]                    pos_inc;
  logic [CMP_W-1:0]                    pos_ext, pos_inc_ext, len;
  logic                                last, height_hit;

  assign pos_inc     = byte_pos + POS_W'(1);
  assign pos_ext     = CMP_W'(byte_pos);
  assign pos_inc_ext = pos_ext + CMP_W'(1);
  assign len         = {cfg.width, 1'b0};
  assign last        = pos_inc_ext >= len;
  assign height_hit  = cur_row == imgdf_pkg::HDR_ROW_W'(cfg.height);

  always_comb begin
    phase_next        = phase;
    sync_history_next = sync_history;
    byte_pos_next     = byte_pos;
    cur_row_next      = cur_row;
    row_ok_next       = row_ok;
    prev_row_next     = prev_row;
    low_hold_next     = low_hold;
    fire              = 1'b0;
    res               = '0;
    unique case (phase)
      PH_HEADER: begin
        if (byte_pos == POS_W'(imgdf_pkg::ROW_OFS_LO)) begin
          cur_row_next = {cur_row[15:8], data};
        end else if (byte_pos == POS_W'(imgdf_pkg::ROW_OFS_HI)) begin
          cur_row_next = {data, cur_row[7:0]};
        end
        byte_pos_next = pos_inc;
        if (CMP_W'(pos_inc) >= CMP_W'(cfg.header)) begin
          row_ok_next = (cur_row_next != '0) &&
                        (cur_row_next <= imgdf_pkg::HDR_ROW_W'(cfg.height));
          if (row_ok_next) begin
            // frame wraps back to its first row
            if (cur_row_next == imgdf_pkg::HDR_ROW_W'(1) &&
                prev_row > imgdf_pkg::HDR_ROW_W'(1)) begin
              fire             = 1'b1;
              res.frame_commit = 1'b1;
            end
            prev_row_next = cur_row_next;
          end
          phase_next    = PH_PAYLOAD;
          byte_pos_next = '0;
        end
      end
      PH_PAYLOAD: begin
        if (!byte_pos[0]) begin
          low_hold_next = data;
        end else if (row_ok) begin
          fire             = 1'b1;
          res.pixel_valid  = 1'b1;
          res.pixel_row    = imgdf_pkg::ROW_W'(cur_row - imgdf_pkg::HDR_ROW_W'(1));
          res.pixel_column = pos_ext[imgdf_pkg::COL_W:1];
          res.pixel_value  = {data, low_hold};
        end
        byte_pos_next = pos_inc;
        if (last && height_hit) begin
          fire             = 1'b1;
          res.frame_commit = 1'b1;
        end
        if (last) begin
          phase_next        = PH_HUNT;
          byte_pos_next     = '0;
          sync_history_next = imgdf_pkg::HIST_CLEAR;
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if (sync_history == imgdf_pkg::SYNC_PREFIX && data == imgdf_pkg::SYNC_LAST) begin
          phase_next        = PH_HEADER;
          byte_pos_next     = POS_W'(imgdf_pkg::SYNC_BYTES);
          cur_row_next      = '0;
          sync_history_next = imgdf_pkg::HIST_CLEAR;
        end else begin
          sync_history_next = {sync_history[15:0], data};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      sync_history <= imgdf_pkg::HIST_CLEAR;
      byte_pos     <= '0;
      cur_row      <= '0;
      row_ok       <= 1'b0;
      prev_row     <= '0;
    end else if (take) begin
      phase        <= phase_next;
      sync_history <= sync_history_next;
      byte_pos     <= byte_pos_next;
      cur_row      <= cur_row_next;
      row_ok       <= row_ok_next;
      prev_row     <= prev_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      low_hold <= low_hold_next;
    end
  end

endmodule

// ===== rtl/image_line_deframer.sv =====
// image_line_deframer: camera byte stream to pixel writes and frame commits.
// Latency: a result word is shown on the cycle after its byte is accepted.
// Throughput: one byte per cycle, set by the single-pass parser; the input
// stalls only while the one-word output register is full and stalled.
// Reset: registers return to 640 x 512 with a 16-byte header, parser hunts.
// Depends on imgdf_pkg and imgdf_parse.
module image_line_deframer #(
  parameter int MAX_LINE_PIXELS = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  // byte stream in
  input  logic                               stream_valid,
  output logic                               stream_stall,
  input  logic [imgdf_pkg::BYTE_W-1:0]       stream_byte,
  // result words out
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               pixel_valid,
  output logic [imgdf_pkg::ROW_W-1:0]        pixel_row,
  output logic [imgdf_pkg::COL_W-1:0]        pixel_column,
  output logic [imgdf_pkg::VALUE_W-1:0]      pixel_value,
  output logic                               frame_commit,
  // register writes
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [imgdf_pkg::CFG_W-1:0]        cfg_data
);

  // Position counter must hold a full payload (two bytes a pixel) and the
  // longest header.
  localparam int LINE_POS_W = $clog2(2 * MAX_LINE_PIXELS);
  localparam int POS_W      = (LINE_POS_W > imgdf_pkg::BYTE_W) ? LINE_POS_W
                                                              : imgdf_pkg::BYTE_W;

  logic [imgdf_pkg::CFG_W-1:0]   frame_width;
  logic [imgdf_pkg::CFG_W-1:0]   frame_height;
  logic [imgdf_pkg::BYTE_W-1:0]  header_bytes;
  imgdf_pkg::eff_cfg_t           eff;
  imgdf_pkg::result_t            res;
  imgdf_pkg::result_t            res_q;
  logic                          take;
  logic                          fire;

  // Register file: an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= imgdf_pkg::WIDTH_RST;
      frame_height <= imgdf_pkg::HEIGHT_RST;
      header_bytes <= imgdf_pkg::HEADER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        imgdf_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        imgdf_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        imgdf_pkg::CFG_HEADER_BYTES: header_bytes <= cfg_data[imgdf_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers into their working ranges.
  always_comb begin
    eff.width = imgdf_pkg::EFF_W_W'(frame_width);
    if (frame_width == '0) begin
      eff.width = imgdf_pkg::EFF_W_W'(1);
    end else if (imgdf_pkg::EFF_W_W'(frame_width) > imgdf_pkg::EFF_W_W'(MAX_LINE_PIXELS)) begin
      eff.width = imgdf_pkg::EFF_W_W'(MAX_LINE_PIXELS);
    end
    eff.height = frame_height;
    if (frame_height == '0) begin
      eff.height = imgdf_pkg::CFG_W'(1);
    end else if (frame_height > imgdf_pkg::MAX_HEIGHT) begin
      eff.height = imgdf_pkg::MAX_HEIGHT;
    end
    eff.header = (header_bytes < imgdf_pkg::MIN_HEADER) ? imgdf_pkg::MIN_HEADER
                                                        : header_bytes;
  end

  // Hold the input only while a finished word waits and the sink stalls.
  assign stream_stall = result_valid && result_stall;
  assign take         = stream_valid && !stream_stall;

  imgdf_parse #(
    .POS_W (POS_W)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .data (stream_byte),
    .cfg  (eff),
    .fire (fire),
    .res  (res)
  );

  // Output register: load on a byte that yields a word, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire) begin
      res_q <= res;
    end
  end

  assign pixel_valid  = res_q.pixel_valid;
  assign pixel_row    = res_q.pixel_row;
  assign pixel_column = res_q.pixel_column;
  assign pixel_value  = res_q.pixel_value;
  assign frame_commit = res_q.frame_commit;

  // A shown word always carries a pixel write or a commit.
  a_word_not_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pixel_valid || frame_commit))
    else $error("result word with neither pixel nor commit");

  // A new word only appears after an accepted byte.
  a_word_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stream_valid && !stream_stall))
    else $error("result word without an accepted byte");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word shown after reset");

endmodule

// ===== tb/sv/image_line_deframer_tb.sv =====
`timescale 1ns / 100ps
// Testbench for image_line_deframer: drives framed camera byte streams with random gaps
// and stalls, predicts every pixel write and frame commit, and checks each result word.
// Depends on imgdf_pkg and the image_line_deframer RTL.

import imgdf_pkg::*;

localparam int LINE_PIXELS = 4096;

typedef enum logic [1:0] {
  PH_HUNT    = 2'd0,
  PH_HEADER  = 2'd1,
  PH_PAYLOAD = 2'd2
} parse_phase_t;

typedef enum int {
  FILL_RANDOM,
  FILL_ONES,
  FILL_ZEROS,
  FILL_SYNC
} fill_t;

// Line-packet parser prediction plus the queue of result words still owed by the block.
class deframer_scoreboard;
  logic [CFG_W-1:0]     width_reg;
  logic [CFG_W-1:0]     height_reg;
  logic [BYTE_W-1:0]    header_reg;
  logic [HIST_W-1:0]    history;
  parse_phase_t         phase;
  logic [13:0]          position;
  logic [HDR_ROW_W-1:0] line_row;
  logic [HDR_ROW_W-1:0] last_row;
  bit                   row_ok;
  logic [BYTE_W-1:0]    low_byte;
  result_t              owed[$];
  int                   errors;

  function new();
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    header_reg = HEADER_RST;
    history    = HIST_CLEAR;
    phase      = PH_HUNT;
    position   = '0;
    line_row   = '0;
    last_row   = '0;
    row_ok     = 1'b0;
    low_byte   = '0;
    errors     = 0;
  endfunction

  function void set_register(cfg_index_t idx, logic [CFG_W-1:0] value);
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = value;
      CFG_FRAME_HEIGHT: height_reg = value;
      CFG_HEADER_BYTES: header_reg = value[BYTE_W-1:0];
      default: ;
    endcase
  endfunction

  // Payload length in bytes, width held to 1..LINE_PIXELS.
  function int line_bytes();
    int w;
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > LINE_PIXELS) w = LINE_PIXELS;
    return 2 * w;
  endfunction

  function int row_limit();
    int h;
    h = int'(height_reg);
    if (h < 1) h = 1;
    if (h > int'(MAX_HEIGHT)) h = int'(MAX_HEIGHT);
    return h;
  endfunction

  function int header_len();
    return (header_reg < MIN_HEADER) ? int'(MIN_HEADER) : int'(header_reg);
  endfunction

  function bit in_packet();
    return phase != PH_HUNT;
  endfunction

  function int pending();
    return owed.size();
  endfunction

  // Advance the parser by one accepted byte and queue any result word it causes.
  function void note_byte(logic [BYTE_W-1:0] b);
    result_t r;
    bit      commit;
    bit      last;
    int      row_now;
    r = '0;
    case (phase)
      PH_HEADER: begin
        if (position == 14'(ROW_OFS_LO)) line_row[7:0] = b;
        else if (position == 14'(ROW_OFS_HI)) line_row[15:8] = b;
        position = position + 14'd1;
        if (int'(position) >= header_len()) begin
          row_now = int'(line_row);
          commit  = 1'b0;
          row_ok  = row_now >= 1 && row_now <= row_limit();
          if (row_ok) begin
            commit   = row_now == 1 && int'(last_row) > 1;
            last_row = line_row;
          end
          phase    = PH_PAYLOAD;
          position = '0;
          if (commit) begin
            r.frame_commit = 1'b1;
            owed.push_back(r);
          end
        end
      end
      PH_PAYLOAD: begin
        last = int'(position) + 1 >= line_bytes();
        if (!position[0]) begin
          low_byte = b;
        end else if (row_ok) begin
          row_now        = int'(line_row) - 1;
          r.pixel_valid  = 1'b1;
          r.pixel_row    = row_now[ROW_W-1:0];
          r.pixel_column = position[COL_W:1];
          r.pixel_value  = {b, low_byte};
        end
        position = position + 14'd1;
        r.frame_commit = last && int'(line_row) == row_limit();
        if (last) begin
          phase    = PH_HUNT;
          position = '0;
          history  = HIST_CLEAR;
        end
        if (r.pixel_valid || r.frame_commit) owed.push_back(r);
      end
      default: begin
        phase = PH_HUNT;
        if (history == SYNC_PREFIX && b == SYNC_LAST) begin
          phase    = PH_HEADER;
          position = 14'(SYNC_BYTES);
          line_row = '0;
          history  = HIST_CLEAR;
        end else begin
          history = {history[HIST_W-9:0], b};
        end
      end
    endcase
  endfunction

  task report(string msg);
    errors++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task check_word(logic v, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                  logic [VALUE_W-1:0] value, logic commit);
    result_t want;
    if (owed.size() == 0) begin
      report($sformatf("unexpected word: valid %0b row %0d col %0d value %04h commit %0b",
                       v, row, col, value, commit));
      return;
    end
    want = owed.pop_front();
    if (v !== want.pixel_valid)
      report($sformatf("pixel_valid got %0b want %0b", v, want.pixel_valid));
    if (row !== want.pixel_row)
      report($sformatf("pixel_row got %0d want %0d", row, want.pixel_row));
    if (col !== want.pixel_column)
      report($sformatf("pixel_column got %0d want %0d", col, want.pixel_column));
    if (value !== want.pixel_value)
      report($sformatf("pixel_value got %04h want %04h", value, want.pixel_value));
    if (commit !== want.frame_commit)
      report($sformatf("frame_commit got %0b want %0b", commit, want.frame_commit));
  endtask
endclass

module image_line_deframer_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               stream_valid = 1'b0;
  logic               stream_stall;
  logic [BYTE_W-1:0]  stream_byte = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               pixel_valid;
  logic [ROW_W-1:0]   pixel_row;
  logic [COL_W-1:0]   pixel_column;
  logic [VALUE_W-1:0] pixel_value;
  logic               frame_commit;
  logic               cfg_write = 1'b0;
  cfg_index_t         cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]   cfg_data = '0;

  deframer_scoreboard sb;
  bit                 calm = 1'b0;           // no idling on either side while set
  bit                 pause_mid_line = 1'b0; // drain once in the middle of a payload
  int                 bytes_sent = 0;
  int                 cycle_count = 0;

  image_line_deframer #(
    .MAX_LINE_PIXELS(LINE_PIXELS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream_byte  (stream_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_valid  (pixel_valid),
    .pixel_row    (pixel_row),
    .pixel_column (pixel_column),
    .pixel_value  (pixel_value),
    .frame_commit (frame_commit),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("image_line_deframer: mismatch");
      $finish;
    end
  end

  // Result side: check every accepted word, then pick the stall for the next edge.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_word(pixel_valid, pixel_row, pixel_column, pixel_value, frame_commit);
    result_stall <= !calm && ($urandom_range(99) < 24);
  end

  // Offer one byte, idling first at random; hold it until the block takes it.
  task automatic send_byte(input logic [BYTE_W-1:0] value);
    while (!calm && $urandom_range(99) < 24) begin
      stream_valid <= 1'b0;
      @(posedge clk);
    end
    stream_valid <= 1'b1;
    stream_byte  <= value;
    @(posedge clk);
    while (stream_stall) @(posedge clk);
    sb.note_byte(value);
    bytes_sent++;
  endtask

  // Drop valid and hold off until every owed word has come out.
  task automatic pause_until_drained();
    stream_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_noise(input int count);
    for (int k = 0; k < count; k++) send_byte(8'($urandom_range(255)));
  endtask

  // One line packet: sync word, header with the row at offsets 8 and 9, then the
  // payload, short by cut bytes.
  task automatic send_packet(input logic [HDR_ROW_W-1:0] row, input int cut,
                             input fill_t fill);
    int                hdr;
    int                len;
    int                roll;
    logic [BYTE_W-1:0] b;
    hdr = sb.header_len();
    len = sb.line_bytes() - cut;
    send_byte(SYNC_PREFIX[23:16]);
    send_byte(SYNC_PREFIX[15:8]);
    send_byte(SYNC_PREFIX[7:0]);
    send_byte(SYNC_LAST);
    for (int k = int'(SYNC_BYTES); k < hdr; k++) begin
      if (k == int'(ROW_OFS_LO)) b = row[7:0];
      else if (k == int'(ROW_OFS_HI)) b = row[15:8];
      else b = 8'($urandom_range(255));
      send_byte(b);
    end
    for (int k = 0; k < len; k++) begin
      if (pause_mid_line && k == len / 2) begin
        pause_until_drained();
        pause_mid_line = 1'b0;
      end
      case (fill)
        FILL_ONES:  b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        FILL_SYNC: begin
          case (k % 4)
            0:       b = SYNC_PREFIX[23:16];
            1:       b = SYNC_PREFIX[15:8];
            2:       b = SYNC_PREFIX[7:0];
            default: b = SYNC_LAST;
          endcase
        end
        default: begin
          // lean on the all-zero and all-one pixel halves now and then
          roll = $urandom_range(19);
          if (roll == 0) b = 8'h00;
          else if (roll == 1) b = 8'hFF;
          else b = 8'($urandom_range(255));
        end
      endcase
      send_byte(b);
    end
  endtask

  // Load one register at the next edge; the caller drops the write enable.
  task automatic write_register(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  // Finish any open packet, let the block go quiet, then load all three registers.
  task automatic configure(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                           input logic [CFG_W-1:0] header);
    cfg_index_t       idx [3];
    logic [CFG_W-1:0] val [3];
    idx = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_HEADER_BYTES};
    val = '{width, height, header};
    while (sb.in_packet()) send_byte(8'($urandom_range(255)));
    pause_until_drained();
    // results are registered behind their byte; leave margin before touching registers
    repeat (4) @(posedge clk);
    for (int k = 0; k < 3; k++) write_register(idx[k], val[k]);
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed frames walking rows 1..height, mixed with rejected rows,
  // broken syncs, short payloads and plain noise.
  task automatic run_random_phase(input int budget);
    int                   start;
    int                   pick;
    int                   shape;
    int                   cut;
    logic [HDR_ROW_W-1:0] row;
    logic [HDR_ROW_W-1:0] next_row;
    start    = bytes_sent;
    next_row = 16'd1;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        row      = next_row;
        next_row = (int'(next_row) >= sb.row_limit()) ? 16'd1 : next_row + 16'd1;
      end else if (pick < 68) row = 16'd1;
      else if (pick < 75) row = 16'(sb.row_limit());
      else if (pick < 81) row = 16'($urandom_range(sb.row_limit(), 1));
      else if (pick < 87) row = 16'd0;
      else if (pick < 93) row = 16'(sb.row_limit() + 1);
      else row = 16'($urandom_range(16'hFFFF));

      shape = $urandom_range(99);
      cut   = 0;
      if (shape < 10) begin
        send_noise($urandom_range(6, 1));
      end else if (shape < 18) begin
        // sync word broken on its last byte
        send_byte(SYNC_PREFIX[23:16]);
        send_byte(SYNC_PREFIX[15:8]);
        send_byte(SYNC_PREFIX[7:0]);
        send_byte(8'($urandom_range(255, 1)));
      end else if (shape < 24 && sb.line_bytes() > 1) begin
        cut = $urandom_range(sb.line_bytes() - 1, 1);
      end
      if (shape < 95) send_packet(row, cut, FILL_RANDOM);
      else send_noise($urandom_range(10, 1));
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset height and header with a short line: commit on the last pixel of row 512.
    write_register(CFG_FRAME_WIDTH, 13'd4);
    cfg_write <= 1'b0;
    send_packet(16'd512, 0, FILL_RANDOM);

    // Directed: one-pixel lines, two rows, header written as zero so the minimum applies.
    configure(13'd1, 13'd2, 13'd0);
    send_packet(16'd2, 0, FILL_ONES);       // last row: pixel and commit together
    send_packet(16'd0, 0, FILL_RANDOM);     // rejected row, previous row stays 2
    send_packet(16'd1, 0, FILL_ZEROS);      // row 1 after row 2: commit on the header
    send_packet(16'h0301, 0, FILL_RANDOM);  // out of range through the high byte
    send_packet(16'd1, 0, FILL_RANDOM);     // row 1 after row 1: no commit
    // A sync word inside the payload must not restart a packet.
    configure(13'd2, 13'd2, 13'd12);
    send_packet(16'd2, 0, FILL_SYNC);
    send_packet(16'd1, 0, FILL_RANDOM);

    // Random phases across register settings; the first runs with no idling at all.
    configure(13'd3, 13'd4, 13'd12);
    calm = 1'b1;
    run_random_phase(120);
    calm = 1'b0;
    configure(13'd0, 13'd0, 13'd40);        // width and height below range, long header
    run_random_phase(60);
    configure(13'd5, 13'd4096, 13'd14);
    pause_mid_line = 1'b1;
    run_random_phase(50);
    configure(13'd2, 13'd3, 13'h1F05);      // header keeps its low byte, 5 acts as 12
    run_random_phase(50);
    configure(13'd4, 13'd6, 13'd20);
    run_random_phase(50);

    // Height held to 4096 on the highest row: pixel_row reaches 4095.
    configure(13'd2, 13'h1FFF, 13'd13);
    send_packet(16'd4096, 0, FILL_RANDOM);
    send_noise(5);

    while (sb.in_packet()) send_byte(8'($urandom_range(255)));
    pause_until_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("image_line_deframer: match");
    end else begin
      $display("image_line_deframer: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/imgdf_pkg.sv
rtl/imgdf_parse.sv
rtl/image_line_deframer.sv
tb/sv/image_line_deframer_tb.sv
